>>> rtl/qbb_pkg.sv
package qbb_pkg;

  // Fixed field widths
  localparam int unsigned BUF_W   = 4;
  localparam int unsigned QUAD_W  = 8;
  localparam int unsigned BLEND_W = 3;
  localparam int unsigned SLOT_W  = 4;

  // Buffer index that marks "no buffer"
  localparam logic [BUF_W-1:0] NONE_IDX = 4'hF;

  // Input commands
  localparam logic [1:0] CMD_TEX   = 2'd0;
  localparam logic [1:0] CMD_FLAT  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_FLUSHED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [BLEND_W-1:0] blend;
    logic [SLOT_W-1:0]  texture_slot;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BUF_W-1:0]   buffer_index;
    logic [QUAD_W-1:0]  quad_index;
    logic [QUAD_W-1:0]  quad_count;
    logic               is_textured;
    logic [BLEND_W-1:0] blend_out;
    logic [SLOT_W-1:0]  slot_out;
    logic               urgent;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLACE,
    S_FL_RD,
    S_FL_HEAD,
    S_FL_WALK
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic idle;
    logic load;
    logic place;
    logic fl_head;
    logic fl_walk;
    logic fl_finish;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic chain_end;
    logic walk_last;
  } sts_t;

endpackage

>>> rtl/qbb_ctrl.sv
module qbb_ctrl import qbb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] command_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o,
  output logic       busy
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        ctl_o.idle = 1'b1;
        if (start) begin
          ctl_o.load = 1'b1;
          case (command_i)
            CMD_TEX, CMD_FLAT: state_d = S_PLACE;
            CMD_FLUSH:         state_d = S_FL_RD;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_PLACE: begin
        ctl_o.place = 1'b1;
        state_d     = S_IDLE;
      end
      S_FL_RD: begin
        state_d = S_FL_HEAD;
      end
      S_FL_HEAD: begin
        ctl_o.fl_head = 1'b1;
        state_d       = S_FL_WALK;
      end
      S_FL_WALK: begin
        ctl_o.fl_walk = 1'b1;
        if (sts_i.chain_end) begin
          if (sts_i.walk_last) begin
            ctl_o.fl_finish = 1'b1;
            state_d         = S_IDLE;
          end else begin
            state_d = S_FL_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/qbb_datapath.sv
module qbb_datapath import qbb_pkg::*; #(
  parameter int unsigned NUM_BUFFERS   = 12,
  parameter int unsigned QUADS_PER_BUF = 150,
  parameter int unsigned NUM_BLENDS    = 6,
  parameter int unsigned NUM_SLOTS     = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  output sts_t              sts_o,
  input  in_t               in_i,
  input  logic              cfg_valid_i,
  input  logic [QUAD_W-1:0] cfg_data_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  localparam int unsigned IW        = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned NBINS     = NUM_BLENDS * (NUM_SLOTS + 1);
  localparam int unsigned AW        = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int unsigned FLAT_BASE = NUM_BLENDS * NUM_SLOTS;

  // Bin address of a (flat, blend, slot) triple
  function automatic logic [AW-1:0] bin_of(input logic flat, input logic [3:0] bl,
                                           input logic [3:0] sl);
    logic [AW+4:0] a;
    if (flat) begin
      a = (AW+5)'(FLAT_BASE) + (AW+5)'(bl);
    end else begin
      a = (AW+5)'(bl) * (AW+5)'(NUM_SLOTS) + (AW+5)'(sl);
    end
    return a[AW-1:0];
  endfunction

  // Placement request within the configured bin space
  function automatic logic in_ok(input in_t r);
    return (32'(r.blend) < NUM_BLENDS) &&
           ((r.command != CMD_TEX) || (32'(r.texture_slot) < NUM_SLOTS));
  endfunction

  // Configuration
  logic [QUAD_W-1:0] limit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Bin head memory with per-entry valid bits
  logic [BUF_W-1:0] head_mem [NBINS];
  logic [NBINS-1:0] vld_q;
  logic [AW-1:0]    rd_addr;
  logic [BUF_W-1:0] rd_q;
  logic             rdv_q;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [BUF_W-1:0] mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      head_mem[mem_wa] <= mem_wd;
    end
    rd_q  <= head_mem[rd_addr];
    rdv_q <= vld_q[rd_addr];
  end

  // Buffer pool and walk state
  logic [BUF_W-1:0]  free_head_q;
  logic [BUF_W-1:0]  next_q [NUM_BUFFERS];
  logic [QUAD_W-1:0] fill_q [NUM_BUFFERS];
  in_t               inq_q;
  logic [3:0]        fbl_q, fs_q, start_q;
  logic [4:0]        fi_q;
  logic [BUF_W-1:0]  cur_q;
  logic [3:0]        steps_q, k_q;
  logic              drew_q, pend_v_q;
  res_t              pend_q;

  // Walk decode
  logic              flat_walk, chain_end, emit;
  logic [QUAD_W-1:0] cur_cnt;
  logic [3:0]        start_new;
  res_t              walk_res;

  assign flat_walk = (32'(fi_q) == NUM_SLOTS);
  assign chain_end = (32'(cur_q) >= NUM_BUFFERS) || (32'(steps_q) >= NUM_BUFFERS);
  assign cur_cnt   = fill_q[cur_q[IW-1:0]];
  assign emit      = !chain_end && (cur_cnt != '0) && (32'(k_q) < NUM_BUFFERS);
  assign start_new = (!flat_walk && drew_q) ? fs_q : start_q;

  always_comb begin
    walk_res              = '0;
    walk_res.status       = ST_FLUSHED;
    walk_res.buffer_index = cur_q;
    walk_res.quad_count   = cur_cnt;
    walk_res.is_textured  = !flat_walk;
    walk_res.blend_out    = fbl_q[BLEND_W-1:0];
    walk_res.slot_out     = flat_walk ? '0 : fs_q;
    walk_res.urgent       = !flat_walk && ((limit_q == '0) || (cur_cnt > limit_q));
  end

  assign sts_o.chain_end = chain_end;
  assign sts_o.walk_last = flat_walk && (32'(fbl_q) == NUM_BLENDS - 1);

  // Placement decode
  logic [BUF_W-1:0] head, chosen;
  logic             need_new, fail;
  logic [AW-1:0]    place_bin;

  assign head      = rdv_q ? rd_q : NONE_IDX;
  assign need_new  = (32'(head) >= NUM_BUFFERS) ||
                     (32'(fill_q[head[IW-1:0]]) >= QUADS_PER_BUF);
  assign chosen    = need_new ? free_head_q : head;
  assign fail      = !in_ok(inq_q) || (need_new && (32'(free_head_q) >= NUM_BUFFERS));
  assign place_bin = bin_of(inq_q.command == CMD_FLAT, {1'b0, inq_q.blend},
                            inq_q.texture_slot);

  // Memory read address: request at accept, walk bin otherwise
  always_comb begin
    if (ctl_i.idle) begin
      rd_addr = in_ok(in_i) ? bin_of(in_i.command == CMD_FLAT, {1'b0, in_i.blend},
                                     in_i.texture_slot) : '0;
    end else begin
      rd_addr = bin_of(flat_walk, fbl_q, fs_q);
    end
  end

  assign mem_we = ctl_i.place && !fail && need_new;
  assign mem_wa = place_bin;
  assign mem_wd = free_head_q;

  // Pool, walk and result registers
  res_t out_d;
  logic out_v_d;

  always_comb begin
    out_d   = '0;
    out_v_d = 1'b0;
    if (ctl_i.place) begin
      out_v_d  = 1'b1;
      out_d.last = 1'b1;
      if (fail) begin
        out_d.status = ST_NOFREE;
      end else begin
        out_d.status       = ST_PLACED;
        out_d.buffer_index = chosen;
        out_d.quad_index   = fill_q[chosen[IW-1:0]];
      end
    end else if (ctl_i.fl_finish) begin
      out_v_d = 1'b1;
      if (pend_v_q) begin
        out_d = pend_q;
      end else begin
        out_d.status = ST_EMPTY;
      end
      out_d.last = 1'b1;
    end else if (ctl_i.fl_walk && emit && pend_v_q) begin
      out_v_d = 1'b1;
      out_d   = pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= out_d;
    if (ctl_i.load) begin
      inq_q <= in_i;
    end
    if (emit && ctl_i.fl_walk) begin
      pend_q <= walk_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
      free_head_q <= '0;
      vld_q       <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        next_q[i] <= (i + 1 < NUM_BUFFERS) ? BUF_W'(i + 1) : NONE_IDX;
        fill_q[i] <= '0;
      end
      fbl_q    <= '0;
      fs_q     <= '0;
      fi_q     <= '0;
      start_q  <= '0;
      cur_q    <= NONE_IDX;
      steps_q  <= '0;
      k_q      <= '0;
      drew_q   <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      res_valid_o <= out_v_d;
      // Flush setup at accept
      if (ctl_i.load && in_i.command == CMD_FLUSH) begin
        fbl_q    <= '0;
        fs_q     <= '0;
        fi_q     <= '0;
        start_q  <= '0;
        k_q      <= '0;
        pend_v_q <= 1'b0;
      end
      // Placement update
      if (ctl_i.place && !fail) begin
        fill_q[chosen[IW-1:0]] <= fill_q[chosen[IW-1:0]] + 1'b1;
        if (need_new) begin
          free_head_q                <= next_q[free_head_q[IW-1:0]];
          next_q[free_head_q[IW-1:0]] <= head;
          vld_q[place_bin]           <= 1'b1;
        end
      end
      // Chain start
      if (ctl_i.fl_head) begin
        cur_q   <= head;
        steps_q <= '0;
        drew_q  <= 1'b0;
      end
      // Chain step or advance to next bin
      if (ctl_i.fl_walk) begin
        if (!chain_end) begin
          cur_q   <= next_q[cur_q[IW-1:0]];
          steps_q <= steps_q + 1'b1;
          if (emit) begin
            pend_v_q <= 1'b1;
            k_q      <= k_q + 1'b1;
            drew_q   <= 1'b1;
          end
        end else begin
          start_q <= start_new;
          if (flat_walk) begin
            fbl_q <= fbl_q + 1'b1;
            fi_q  <= '0;
            fs_q  <= start_new;
          end else begin
            fi_q <= fi_q + 1'b1;
            fs_q <= (32'(fs_q) == NUM_SLOTS - 1) ? '0 : fs_q + 1'b1;
          end
        end
      end
      // End of flush: return every buffer, empty every bin
      if (ctl_i.fl_finish) begin
        free_head_q <= '0;
        vld_q       <= '0;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          next_q[i] <= (i + 1 < NUM_BUFFERS) ? BUF_W'(i + 1) : NONE_IDX;
          fill_q[i] <= '0;
        end
        k_q      <= '0;
        pend_v_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_free_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(free_head_q) < NUM_BUFFERS) || (free_head_q == NONE_IDX))
    else $error("free list head out of pool");
  a_pend_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q == (k_q != '0))
    else $error("pending result and flush count disagree");
  a_k_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(k_q) <= NUM_BUFFERS)
    else $error("too many flushed buffers");
  a_place_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.place |=> res_valid_o)
    else $error("placement gave no result");
`endif

endmodule

>>> rtl/quad_batch_binner_core.sv
// Placement: start leads to S_PLACE and a registered result; no new start is taken in S_PLACE.
// Flush: each bin takes a head memory read (S_FL_RD), chain setup (S_FL_HEAD) and a walk
//   (S_FL_WALK) that steps once per chained buffer and ends on the chain end check.
// Flush results come as the walk finds buffers, at most one per cycle, each held back
//   until the next found buffer or the end of the walk. No stall from the receiver.
// Reset (async, active low) empties all bins, links every buffer onto the free list, limit 0.
module quad_batch_binner_core import qbb_pkg::*; #(
  parameter int unsigned NUM_BUFFERS   = 12,
  parameter int unsigned QUADS_PER_BUF = 150,
  parameter int unsigned NUM_BLENDS    = 6,
  parameter int unsigned NUM_SLOTS     = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  in_t               in_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [QUAD_W-1:0] cfg_data_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  ctl_t ctl;
  sts_t sts;

  // Limit register takes a write at any time
  assign cfg_ready_o = 1'b1;

  qbb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (in_i.command),
    .sts_i     (sts),
    .ctl_o     (ctl),
    .busy      (busy)
  );

  qbb_datapath #(
    .NUM_BUFFERS   (NUM_BUFFERS),
    .QUADS_PER_BUF (QUADS_PER_BUF),
    .NUM_BLENDS    (NUM_BLENDS),
    .NUM_SLOTS     (NUM_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

>>> tb/quad_batch_binner_core_test.sv
`timescale 1ns / 100ps

module quad_batch_binner_core_test;
  import qbb_pkg::*;

  localparam int unsigned N_BUF    = 12;
  localparam int unsigned QPB      = 150;
  localparam int unsigned N_BLEND  = 6;
  localparam int unsigned N_SLOT   = 11;
  localparam int unsigned N_BIN    = N_BLEND * (N_SLOT + 1);
  localparam int unsigned DRAIN_CY = 3 * N_BIN + N_BUF + 40;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  in_t               in_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [QUAD_W-1:0] cfg_data_i;
  logic              res_valid_o;
  res_t              res_o;

  quad_batch_binner_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Shadow of the buffer pool
  logic [7:0]       count_limit;
  logic [BUF_W-1:0] free_top;
  logic [BUF_W-1:0] link_of [N_BUF];
  logic [7:0]       quads_in [N_BUF];
  logic [BUF_W-1:0] bin_top [N_BIN];

  in_t  pending_cmds[$];
  res_t expected_res[$];
  int   errors;

  function automatic res_t blank_res();
    res_t r;
    r = '0;
    return r;
  endfunction

  function automatic void clear_pool();
    for (int i = 0; i < N_BUF; i++) begin
      link_of[i]  = (i + 1 < N_BUF) ? BUF_W'(i + 1) : NONE_IDX;
      quads_in[i] = '0;
    end
    free_top = '0;
    for (int i = 0; i < N_BIN; i++) bin_top[i] = NONE_IDX;
  endfunction

  // Walk one chain newest first, pushing flushed buffer entries
  function automatic bit emit_chain(int bin, bit tex, int bl, int sl, ref int nres);
    logic [BUF_W-1:0] b;
    res_t             r;
    bit               drew;
    b    = bin_top[bin];
    drew = 1'b0;
    for (int st = 0; st < N_BUF && b < N_BUF; st++) begin
      if (quads_in[b] != 0 && nres < N_BUF) begin
        r              = blank_res();
        r.status       = ST_FLUSHED;
        r.buffer_index = b;
        r.quad_count   = quads_in[b];
        r.is_textured  = tex;
        r.blend_out    = BLEND_W'(bl);
        r.slot_out     = tex ? SLOT_W'(sl) : '0;
        r.urgent       = tex && (count_limit == 0 || quads_in[b] > count_limit);
        expected_res.push_back(r);
        nres++;
        drew = 1'b1;
      end
      b = link_of[b];
    end
    return drew;
  endfunction

  // Predict results of one accepted command
  function automatic void predict_binning(in_t c);
    res_t             r;
    int               bin;
    int               nres;
    int               first_slot;
    int               s;
    logic [BUF_W-1:0] b;
    r        = blank_res();
    r.last   = 1'b1;
    if (c.command == CMD_TEX || c.command == CMD_FLAT) begin
      r.status = ST_NOFREE;
      if (c.blend < N_BLEND && !(c.command == CMD_TEX && c.texture_slot >= N_SLOT)) begin
        bin = (c.command == CMD_TEX) ? c.blend * N_SLOT + c.texture_slot
                                     : N_BLEND * N_SLOT + c.blend;
        b = bin_top[bin];
        if (b >= N_BUF || quads_in[b] >= QPB) begin
          b = free_top;
          if (b < N_BUF) begin
            free_top     = link_of[b];
            link_of[b]   = bin_top[bin];
            bin_top[bin] = b;
          end
        end
        if (b < N_BUF) begin
          r.status       = ST_PLACED;
          r.buffer_index = b;
          r.quad_index   = quads_in[b];
          quads_in[b]++;
        end
      end
      expected_res.push_back(r);
    end else if (c.command == CMD_FLUSH) begin
      nres       = 0;
      first_slot = 0;
      for (int bl = 0; bl < N_BLEND; bl++) begin
        s = first_slot;
        for (int i = 0; i < N_SLOT; i++) begin
          if (emit_chain(bl * N_SLOT + s, 1'b1, bl, s, nres)) first_slot = s;
          s = (s + 1 == N_SLOT) ? 0 : s + 1;
        end
        void'(emit_chain(N_BLEND * N_SLOT + bl, 1'b0, bl, 0, nres));
      end
      clear_pool();
      if (nres == 0) begin
        r.status = ST_EMPTY;
        expected_res.push_back(r);
      end else begin
        r = expected_res.pop_back();
        r.last = 1'b1;
        expected_res.push_back(r);
      end
    end
  endfunction

  function automatic in_t make_cmd(logic [1:0] c, int bl, int sl);
    in_t x;
    x.command      = c;
    x.blend        = BLEND_W'(bl);
    x.texture_slot = SLOT_W'(sl);
    return x;
  endfunction

  // Mostly legal placements on a few hot bins, some noise
  function automatic in_t rand_cmd();
    int p;
    p = $urandom_range(0, 99);
    if (p < 6) return make_cmd(CMD_FLUSH, $urandom_range(0, 7), $urandom_range(0, 15));
    if (p < 10) return make_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 7),
                                $urandom_range(0, 15));
    if (p < 30) return make_cmd(CMD_FLAT, $urandom_range(0, 5), $urandom_range(0, 15));
    if (p < 70) return make_cmd(CMD_TEX, $urandom_range(0, 1), $urandom_range(0, 3));
    return make_cmd(CMD_TEX, $urandom_range(0, 5), $urandom_range(0, 10));
  endfunction

  // Driver: random gaps, sometimes long
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      in_i     <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_binning(in_i);
      end
      if (start && busy) begin
        // hold the item until taken
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() > 0) begin
        start    <= 1'b1;
        in_i     <= pending_cmds.pop_front();
        gap_left <= ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                               : $urandom_range(10, 40);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, res_o);
        errors++;
      end else begin
        exp_r = expected_res.pop_front();
        if (res_o !== exp_r) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, res_o);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CY) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    count_limit = v;
  endtask

  // Stimulus
  initial begin
    logic [7:0] limits [4];
    errors      = 0;
    count_limit = '0;
    clear_pool();
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty flush, extremes, rejects, ignored command
    pending_cmds.push_back(make_cmd(CMD_FLUSH, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_TEX, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_TEX, 5, 10));
    pending_cmds.push_back(make_cmd(CMD_FLAT, 5, 15));
    pending_cmds.push_back(make_cmd(CMD_FLAT, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_TEX, 6, 3));
    pending_cmds.push_back(make_cmd(CMD_TEX, 7, 15));
    pending_cmds.push_back(make_cmd(CMD_TEX, 2, 11));
    pending_cmds.push_back(make_cmd(CMD_TEX, 2, 15));
    pending_cmds.push_back(make_cmd(CMD_FLAT, 7, 0));
    pending_cmds.push_back(make_cmd(2'd3, 7, 15));
    pending_cmds.push_back(make_cmd(CMD_TEX, 3, 7));
    pending_cmds.push_back(make_cmd(CMD_TEX, 3, 2));
    pending_cmds.push_back(make_cmd(CMD_FLUSH, 7, 15));
    wait_drained();

    // Random phases over several limits; one fills a buffer and runs out of pool
    limits[0] = 8'd0;
    limits[1] = 8'd150;
    limits[2] = 8'd1;
    limits[3] = 8'($urandom_range(2, 149));
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      for (int i = 0; i < 20; i++) pending_cmds.push_back(rand_cmd());
      if (ph == 1) begin
        // Overfill: one full buffer, then distinct bins until the pool is gone
        pending_cmds.push_back(make_cmd(CMD_FLUSH, 0, 0));
        for (int i = 0; i < QPB + 1; i++)
          pending_cmds.push_back(make_cmd(CMD_TEX, 0, 0));
        for (int i = 0; i < N_BUF; i++)
          pending_cmds.push_back(make_cmd(CMD_TEX, i / N_SLOT + 1, i % N_SLOT));
        pending_cmds.push_back(make_cmd(CMD_FLUSH, 0, 0));
      end
      for (int i = 0; i < 15; i++) pending_cmds.push_back(rand_cmd());
      pending_cmds.push_back(make_cmd(CMD_FLUSH, 0, 0));
      wait_drained();
    end

    if (errors == 0 && expected_res.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
